@@ rtl/cse_pkg.sv @@
// Shared types and constants for the Chebyshev series evaluator.
// Field widths, fixed-point formats, stream packing and the pipeline item record.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package cse_pkg;

	// Number of series terms, and therefore of term stages.
	localparam int NUM_TERMS = 10;
	localparam int TERM_W    = $clog2(NUM_TERMS);

	// Field widths fixed by the stream format.
	localparam int IDX_W  = 4;
	localparam int COEF_W = 24;
	localparam int X_W    = 18;
	localparam int OUT_W  = 28;

	// Fixed-point layout: Q1.16 for x and T_k, Q7.16 coefficients.
	localparam int FRAC   = 16;
	localparam int HALF   = 1 << (FRAC - 1);
	localparam int T_W    = X_W;
	localparam int PROD_W = COEF_W + T_W;
	localparam int ACC_W  = PROD_W + $clog2(NUM_TERMS) + 3;
	localparam int RND_W  = ACC_W - FRAC;

	localparam logic signed [T_W-1:0] T_ONE       = T_W'(65536);
	localparam logic signed [T_W-1:0] T_MINUS_ONE = T_W'(-65536);

	// Stream packing, first field in the lowest bits.
	localparam int COEF_LSB   = IDX_W;
	localparam int X_LSB      = COEF_LSB + COEF_W;
	localparam int IN_DATA_W  = ((X_LSB + X_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_t;

	// One item as it travels down the pipeline. t_a holds T_k and t_b holds
	// T_(k-1) on entry to term stage k; prod is the product of the term before.
	typedef struct packed {
		cmd_t                     cmd;
		logic [IDX_W-1:0]         idx;
		logic signed [COEF_W-1:0] coeff;
		logic signed [T_W-1:0]    x;
		logic signed [T_W-1:0]    t_a;
		logic signed [T_W-1:0]    t_b;
		logic signed [PROD_W-1:0] prod;
		logic signed [ACC_W-1:0]  acc;
		logic                     sat;
	} cse_item_t;

endpackage

@@ rtl/cse_term.sv @@
// One term stage of the Chebyshev series pipeline.
// Holds coefficient c_k, forms c_k*T_k, steps the recurrence to T_(k+1) and
// adds the previous term's product to the running sum. Depends on cse_pkg.
`timescale 1ns / 1ps

module cse_term import cse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [TERM_W-1:0] term_idx,
	input  logic              prev_valid,
	input  cse_item_t         prev_item,
	output logic              next_valid,
	output cse_item_t         next_item
);

	localparam int XT_W = 2 * T_W;
	localparam int TR_W = XT_W + 1 - FRAC;
	localparam int TD_W = TR_W + 1;

	localparam logic signed [XT_W:0]   XT_HALF = (XT_W + 1)'(HALF);
	localparam logic signed [TD_W-1:0] D_ONE   = TD_W'(65536);
	localparam logic signed [TD_W-1:0] D_MONE  = TD_W'(-65536);

	logic signed [COEF_W-1:0] coef_q;
	logic                     coef_wr;

	logic signed [XT_W-1:0]   xt;
	logic signed [XT_W:0]     xt2r;
	logic signed [TR_W-1:0]   t_rnd;
	logic signed [TD_W-1:0]   t_diff;
	logic signed [T_W-1:0]    t_next;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [ACC_W-1:0]  acc_c;
	cse_item_t                item_c;

	logic      valid_sk;
	cse_item_t item_sk;

	// A coefficient write updates this stage as it passes, so items ahead of
	// it keep the old value and items behind it see the new one.
	assign coef_wr = en && prev_valid && (prev_item.cmd == CMD_WRITE)
		&& (32'(prev_item.idx) == 32'(term_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (coef_wr) begin
			coef_q <= prev_item.coeff;
		end
	end

	always_comb begin
		xt     = $signed(prev_item.x) * $signed(prev_item.t_a);
		xt2r   = $signed({xt, 1'b0}) + XT_HALF;
		t_rnd  = xt2r[XT_W:FRAC];
		t_diff = TD_W'(t_rnd) - TD_W'($signed(prev_item.t_b));
		if (t_diff > D_ONE) begin
			t_next = T_ONE;
		end else if (t_diff < D_MONE) begin
			t_next = T_MINUS_ONE;
		end else begin
			t_next = t_diff[T_W-1:0];
		end
		prod_c = coef_q * $signed(prev_item.t_a);
		acc_c  = $signed(prev_item.acc) + ACC_W'($signed(prev_item.prod));

		item_c      = prev_item;
		item_c.t_a  = t_next;
		item_c.t_b  = prev_item.t_a;
		item_c.prod = prod_c;
		item_c.acc  = acc_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk <= 1'b0;
		end else if (en) begin
			valid_sk <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_sk <= item_c;
		end
	end

	assign next_valid = valid_sk;
	assign next_item  = item_sk;

endmodule

@@ rtl/chebyshev_series_evaluator.sv @@
// Top level of the Chebyshev series evaluator: stream ports, entry stage with
// clipping of x, a chain of cse_term stages, final sum and output rounding.
// Depends on cse_pkg and cse_term.
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tuser: cmd; tdata: coeff_index, coeff_value, x_value
// m_axis    out        tuser: saturated; tdata: series_value
//
// One transfer is taken per clock cycle unless the output stalls; write and
// evaluate items share the pipeline, which has NUM_TERMS + 3 register stages
// (entry, one per term, final sum, output).
// Reset clears the valid bits and the coefficients held in the term stages.
// When the output holds a result that is not taken, the whole pipeline stops
// and s_axis_tready falls in the same cycle.

module chebyshev_series_evaluator import cse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [3:0] coeff_index, [27:4] coeff_value, [45:28] x_value, [47:46] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] cmd
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [27:0] series_value, [31:28] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [0] saturated
	output logic [0:0]            m_axis_tuser
);

	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(HALF);

	logic                 en;
	logic signed [X_W-1:0] in_x;
	logic signed [X_W-1:0] x_clip;
	logic                 x_sat;

	logic      entry_valid_s1;
	cse_item_t entry_item_s1;

	logic      chain_valid [NUM_TERMS+1];
	cse_item_t chain_item  [NUM_TERMS+1];

	logic                    sum_valid_sacc;
	cmd_t                    sum_cmd_sacc;
	logic                    sum_sat_sacc;
	logic signed [ACC_W-1:0] sum_acc_sacc;

	logic signed [ACC_W-1:0] acc_r;
	logic signed [RND_W-1:0] rnd;
	logic                    ovf;
	logic signed [OUT_W-1:0] series_c;

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] series_q;
	logic                    sat_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	assign in_x = s_axis_tdata[X_LSB +: X_W];

	always_comb begin
		x_sat  = 1'b0;
		x_clip = in_x;
		if (in_x > T_ONE) begin
			x_sat  = 1'b1;
			x_clip = T_ONE;
		end else if (in_x < T_MINUS_ONE) begin
			x_sat  = 1'b1;
			x_clip = T_MINUS_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_s1 <= 1'b0;
		end else if (en) begin
			entry_valid_s1 <= s_axis_tvalid;
		end
	end

	// T_0 = 1 and T_(-1) = x, so the first stage's recurrence yields T_1 = x.
	always_ff @(posedge clk) begin
		if (en) begin
			entry_item_s1.cmd   <= cmd_t'(s_axis_tuser[0]);
			entry_item_s1.idx   <= s_axis_tdata[IDX_W-1:0];
			entry_item_s1.coeff <= s_axis_tdata[COEF_LSB +: COEF_W];
			entry_item_s1.x     <= x_clip;
			entry_item_s1.t_a   <= T_ONE;
			entry_item_s1.t_b   <= x_clip;
			entry_item_s1.prod  <= '0;
			entry_item_s1.acc   <= '0;
			entry_item_s1.sat   <= x_sat;
		end
	end

	assign chain_valid[0] = entry_valid_s1;
	assign chain_item[0]  = entry_item_s1;

	for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
		cse_term u_term (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.term_idx   (TERM_W'(k)),
			.prev_valid (chain_valid[k]),
			.prev_item  (chain_item[k]),
			.next_valid (chain_valid[k+1]),
			.next_item  (chain_item[k+1])
		);
	end

	// The last term's product is still outstanding after the final term stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_sacc <= 1'b0;
		end else if (en) begin
			sum_valid_sacc <= chain_valid[NUM_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_cmd_sacc <= chain_item[NUM_TERMS].cmd;
			sum_sat_sacc <= chain_item[NUM_TERMS].sat;
			sum_acc_sacc <= $signed(chain_item[NUM_TERMS].acc)
				+ ACC_W'($signed(chain_item[NUM_TERMS].prod));
		end
	end

	// Round half up to 16 fraction bits, then clip when the bits above the
	// output sign bit disagree with it.
	always_comb begin
		acc_r = sum_acc_sacc + ACC_HALF;
		rnd   = acc_r[ACC_W-1:FRAC];
		ovf   = !((&rnd[RND_W-1:OUT_W-1]) || !(|rnd[RND_W-1:OUT_W-1]));
		if (ovf) begin
			series_c = rnd[RND_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
				: {1'b0, {(OUT_W-1){1'b1}}};
		end else begin
			series_c = rnd[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sum_valid_sacc && (sum_cmd_sacc == CMD_EVAL);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			series_q <= series_c;
			sat_q    <= sum_sat_sacc || ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-OUT_W){1'b0}}, series_q};
	assign m_axis_tuser  = sat_q;

endmodule
